// ----- rtl/fraction_arith_reduce_assert.svh -----
// Assertion macros shared by the fraction reducer checks.
`ifndef FRACTION_ARITH_REDUCE_ASSERT_SVH
`define FRACTION_ARITH_REDUCE_ASSERT_SVH

// Same-cycle implication, disabled while reset is low.
`define FAR_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
    else $error("fraction_arith_reduce check failed");

// Next-cycle implication, disabled while reset is low.
`define FAR_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
    else $error("fraction_arith_reduce check failed");

`endif

// ----- rtl/frac_pkg.sv -----
// Shared constants and types for the fraction arithmetic reducer.
package frac_pkg;

  localparam int OW    = 16;             // operand width
  localparam int PW    = 2 * OW;         // product width
  localparam int GW    = 2 * OW + 1;     // raw term width (sum may carry)
  localparam int NUM_W = 33;
  localparam int DEN_W = 32;
  localparam int EXT_W = (GW > NUM_W) ? GW : NUM_W;
  localparam int KW    = $clog2(GW + 1); // width of the common power-of-two count
  localparam int CW    = $clog2(GW);     // divider step counter width

  typedef enum logic [1:0] {
    OP_ADD = 2'd0,
    OP_SUB = 2'd1,
    OP_MUL = 2'd2,
    OP_DIV = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    F_IDLE,
    F_MUL,
    F_ADD
  } front_e;

  typedef enum logic [1:0] {
    B_IDLE,
    B_GCD,
    B_DIV,
    B_OUT
  } back_e;

  // Raw unreduced result in sign-magnitude form.
  typedef struct packed {
    logic          num_neg;
    logic [GW-1:0] num_mag;
    logic          den_neg;
    logic [GW-1:0] den_mag;
  } raw_t;

endpackage

// ----- rtl/frac_front.sv -----
// Front end: takes an item, cross-multiplies and forms the raw terms.
module frac_front (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       push_i,
  output logic                       full_o,
  input  logic [1:0]                 operation_i,
  input  logic signed [frac_pkg::OW-1:0] p_numerator_i,
  input  logic signed [frac_pkg::OW-1:0] p_denominator_i,
  input  logic signed [frac_pkg::OW-1:0] q_numerator_i,
  input  logic signed [frac_pkg::OW-1:0] q_denominator_i,
  input  logic                       q_full_i,
  output logic                       q_push_o,
  output frac_pkg::raw_t             q_data_o
);

  frac_pkg::front_e state_q, state_d;
  frac_pkg::op_e    op_q;
  logic [frac_pkg::OW-1:0] pn_q, pd_q, qn_q, qd_q;
  logic [frac_pkg::PW-1:0] p1_q, p2_q, p3_q, p1_d, p2_d, p3_d;
  logic s1_q, s2_q, s3_q, s1_d, s2_d, s3_d;

  function automatic logic [frac_pkg::OW-1:0] mag_of(input logic [frac_pkg::OW-1:0] v);
    mag_of = v[frac_pkg::OW-1] ? (~v + 1'b1) : v;
  endfunction

  logic [frac_pkg::OW-1:0] b1, b3;
  logic nb1, nb3;
  logic t2_neg;
  logic [frac_pkg::GW-1:0] e1, e2, sum_mag;
  logic sum_neg;

  // operand selection and products
  always_comb begin
    b1   = (op_q == frac_pkg::OP_MUL) ? qn_q : qd_q;
    b3   = (op_q == frac_pkg::OP_DIV) ? qn_q : qd_q;
    nb1  = b1[frac_pkg::OW-1];
    nb3  = b3[frac_pkg::OW-1];
    p1_d = frac_pkg::PW'(mag_of(pn_q)) * frac_pkg::PW'(mag_of(b1));
    p2_d = frac_pkg::PW'(mag_of(pd_q)) * frac_pkg::PW'(mag_of(qn_q));
    p3_d = frac_pkg::PW'(mag_of(pd_q)) * frac_pkg::PW'(mag_of(b3));
    s1_d = (p1_d != '0) && (pn_q[frac_pkg::OW-1] ^ nb1);
    s2_d = (p2_d != '0) && (pd_q[frac_pkg::OW-1] ^ qn_q[frac_pkg::OW-1]);
    s3_d = (p3_d != '0) && (pd_q[frac_pkg::OW-1] ^ nb3);
  end

  // signed-magnitude add of the two cross terms (add/sub), and raw term output
  always_comb begin
    t2_neg = s2_q ^ ((op_q == frac_pkg::OP_SUB) && (p2_q != '0));
    e1     = frac_pkg::GW'(p1_q);
    e2     = frac_pkg::GW'(p2_q);
    if (s1_q == t2_neg) begin
      sum_mag = e1 + e2;
      sum_neg = s1_q;
    end else if (e1 >= e2) begin
      sum_mag = e1 - e2;
      sum_neg = s1_q;
    end else begin
      sum_mag = e2 - e1;
      sum_neg = t2_neg;
    end
    if (sum_mag == '0) begin
      sum_neg = 1'b0;
    end
    if ((op_q == frac_pkg::OP_ADD) || (op_q == frac_pkg::OP_SUB)) begin
      q_data_o.num_neg = sum_neg;
      q_data_o.num_mag = sum_mag;
    end else begin
      q_data_o.num_neg = s1_q;
      q_data_o.num_mag = e1;
    end
    q_data_o.den_neg = s3_q;
    q_data_o.den_mag = frac_pkg::GW'(p3_q);
  end

  always_comb begin
    state_d  = state_q;
    q_push_o = 1'b0;
    full_o   = 1'b1;
    case (state_q)
      frac_pkg::F_IDLE: begin
        full_o = 1'b0;
        if (push_i) begin
          state_d = frac_pkg::F_MUL;
        end
      end
      frac_pkg::F_MUL: begin
        state_d = frac_pkg::F_ADD;
      end
      frac_pkg::F_ADD: begin
        if (!q_full_i) begin
          q_push_o = 1'b1;
          state_d  = frac_pkg::F_IDLE;
        end
      end
      default: begin
        state_d = frac_pkg::F_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= frac_pkg::F_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if ((state_q == frac_pkg::F_IDLE) && push_i) begin
      op_q <= frac_pkg::op_e'(operation_i);
      pn_q <= p_numerator_i;
      pd_q <= p_denominator_i;
      qn_q <= q_numerator_i;
      qd_q <= q_denominator_i;
    end
    if (state_q == frac_pkg::F_MUL) begin
      p1_q <= p1_d;
      p2_q <= p2_d;
      p3_q <= p3_d;
      s1_q <= s1_d;
      s2_q <= s2_d;
      s3_q <= s3_d;
    end
  end

endmodule

// ----- rtl/frac_queue.sv -----
// Two-entry queue between front and back ends.
module frac_queue (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  output logic           full_o,
  input  frac_pkg::raw_t wdata_i,
  input  logic           pop_i,
  output logic           empty_o,
  output frac_pkg::raw_t rdata_o
);

  frac_pkg::raw_t mem_q [2];
  logic       wr_q, rd_q;
  logic [1:0] cnt_q;

  assign full_o  = (cnt_q == 2'd2);
  assign empty_o = (cnt_q == 2'd0);
  assign rdata_o = mem_q[rd_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (push_i && !full_o) begin
        wr_q <= ~wr_q;
      end
      if (pop_i && !empty_o) begin
        rd_q <= ~rd_q;
      end
      cnt_q <= cnt_q + 2'((push_i && !full_o) ? 1 : 0) - 2'((pop_i && !empty_o) ? 1 : 0);
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i && !full_o) begin
      mem_q[wr_q] <= wdata_i;
    end
  end

endmodule

// ----- rtl/frac_back.sv -----
// Back end: binary GCD, two-lane restoring divide, sign fix, result register.
module frac_back (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               q_empty_i,
  output logic                               q_pop_o,
  input  frac_pkg::raw_t                     q_data_i,
  output logic                               empty_o,
  input  logic                               pop_i,
  output logic signed [frac_pkg::NUM_W-1:0]  result_numerator_o,
  output logic signed [frac_pkg::DEN_W-1:0]  result_denominator_o,
  output logic                               error_o
);

  localparam int GW = frac_pkg::GW;

  frac_pkg::back_e state_q, state_d;
  logic          nneg_q, dneg_q, err_q;
  logic [GW-1:0] a_q, b_q, a_d, b_d;
  logic [frac_pkg::KW-1:0] k_q, k_d;
  logic [GW-1:0] g_q;
  logic [GW-1:0] xn_q, xd_q, xn_d, xd_d;
  logic [GW:0]   rn_q, rd_q, rn_d, rd_d, rn_sh, rd_sh;
  logic [frac_pkg::CW-1:0] cnt_q;
  logic          gcd_done, ge_n, ge_d;

  logic                      valid_q;
  logic [frac_pkg::NUM_W-1:0] rnum_q;
  logic [frac_pkg::DEN_W-1:0] rden_q;
  logic                      rerr_q;
  logic                      out_free, flip;
  logic [frac_pkg::EXT_W-1:0] nm_ext, dm_ext, nf, df;

  assign empty_o              = ~valid_q;
  assign result_numerator_o   = rnum_q;
  assign result_denominator_o = rden_q;
  assign error_o              = rerr_q;
  assign out_free             = ~valid_q | pop_i;

  // one Stein step
  assign gcd_done = (a_q == '0) || (b_q == '0);
  always_comb begin
    a_d = a_q;
    b_d = b_q;
    k_d = k_q;
    if (!a_q[0] && !b_q[0]) begin
      a_d = a_q >> 1;
      b_d = b_q >> 1;
      k_d = k_q + 1'b1;
    end else if (!a_q[0]) begin
      a_d = a_q >> 1;
    end else if (!b_q[0]) begin
      b_d = b_q >> 1;
    end else if (a_q >= b_q) begin
      a_d = (a_q - b_q) >> 1;
    end else begin
      b_d = (b_q - a_q) >> 1;
    end
  end

  // one quotient bit per lane
  always_comb begin
    rn_sh = {rn_q[GW-1:0], xn_q[GW-1]};
    rd_sh = {rd_q[GW-1:0], xd_q[GW-1]};
    ge_n  = rn_sh >= {1'b0, g_q};
    ge_d  = rd_sh >= {1'b0, g_q};
    rn_d  = ge_n ? (rn_sh - {1'b0, g_q}) : rn_sh;
    rd_d  = ge_d ? (rd_sh - {1'b0, g_q}) : rd_sh;
    xn_d  = {xn_q[GW-2:0], ge_n};
    xd_d  = {xd_q[GW-2:0], ge_d};
  end

  // sign move and field wrap
  always_comb begin
    flip   = dneg_q && (xn_q != '0);
    nm_ext = frac_pkg::EXT_W'(xn_q);
    dm_ext = frac_pkg::EXT_W'(xd_q);
    nf     = (nneg_q ^ flip) ? (~nm_ext + 1'b1) : nm_ext;
    df     = (dneg_q & ~flip) ? (~dm_ext + 1'b1) : dm_ext;
  end

  always_comb begin
    state_d = state_q;
    q_pop_o = 1'b0;
    case (state_q)
      frac_pkg::B_IDLE: begin
        if (!q_empty_i) begin
          q_pop_o = 1'b1;
          if ((q_data_i.num_mag == '0) && (q_data_i.den_mag == '0)) begin
            state_d = frac_pkg::B_OUT;
          end else begin
            state_d = frac_pkg::B_GCD;
          end
        end
      end
      frac_pkg::B_GCD: begin
        if (gcd_done) begin
          state_d = frac_pkg::B_DIV;
        end
      end
      frac_pkg::B_DIV: begin
        if (cnt_q == '0) begin
          state_d = frac_pkg::B_OUT;
        end
      end
      frac_pkg::B_OUT: begin
        if (out_free) begin
          state_d = frac_pkg::B_IDLE;
        end
      end
      default: begin
        state_d = frac_pkg::B_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= frac_pkg::B_IDLE;
      valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if ((state_q == frac_pkg::B_OUT) && out_free) begin
        valid_q <= 1'b1;
      end else if (pop_i) begin
        valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    case (state_q)
      frac_pkg::B_IDLE: begin
        nneg_q <= q_data_i.num_neg;
        dneg_q <= q_data_i.den_neg;
        a_q    <= q_data_i.num_mag;
        b_q    <= q_data_i.den_mag;
        xn_q   <= q_data_i.num_mag;
        xd_q   <= q_data_i.den_mag;
        k_q    <= '0;
        err_q  <= (q_data_i.num_mag == '0) && (q_data_i.den_mag == '0);
      end
      frac_pkg::B_GCD: begin
        a_q <= a_d;
        b_q <= b_d;
        k_q <= k_d;
        if (gcd_done) begin
          g_q   <= GW'((a_q | b_q) << k_q);
          rn_q  <= '0;
          rd_q  <= '0;
          cnt_q <= frac_pkg::CW'(GW - 1);
        end
      end
      frac_pkg::B_DIV: begin
        rn_q  <= rn_d;
        rd_q  <= rd_d;
        xn_q  <= xn_d;
        xd_q  <= xd_d;
        cnt_q <= cnt_q - 1'b1;
      end
      frac_pkg::B_OUT: begin
        if (out_free) begin
          rerr_q <= err_q;
          rnum_q <= err_q ? '0 : nf[frac_pkg::NUM_W-1:0];
          rden_q <= err_q ? '0 : df[frac_pkg::DEN_W-1:0];
        end
      end
      default: begin
      end
    endcase
  end

endmodule

// ----- rtl/fraction_arith_reduce.sv -----
// Top level: fraction add/sub/mul/div with GCD reduction.
//
//  channel  | handshake        | beat
//  ---------+------------------+---------------------------------------------
//  input    | push / full      | operation, p and q numerators/denominators
//  result   | empty / pop      | result_numerator, result_denominator, error
//
// Front end registers a beat while idle, registers the cross products, then
// forms the add and drops the raw terms into a two-entry queue, waiting while
// the queue is full; full stays high until the front end is idle again.
// Back end per item: a load step, binary GCD steps, a restoring divide over
// 2*OPERAND_WIDTH+1 quotient bits (both terms in parallel) and an output step;
// the GCD loop sets the spread. A both-zero item skips GCD and divide.
// Reset clears only control state; no clearing pass. A held result stalls the
// back end, so the queue and then the front end fill and full stays high.
module fraction_arith_reduce (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                push,
  output logic                                full,
  input  logic [1:0]                          operation_i,
  input  logic signed [frac_pkg::OW-1:0]      p_numerator_i,
  input  logic signed [frac_pkg::OW-1:0]      p_denominator_i,
  input  logic signed [frac_pkg::OW-1:0]      q_numerator_i,
  input  logic signed [frac_pkg::OW-1:0]      q_denominator_i,
  output logic                                empty,
  input  logic                                pop,
  output logic signed [frac_pkg::NUM_W-1:0]   result_numerator_o,
  output logic signed [frac_pkg::DEN_W-1:0]   result_denominator_o,
  output logic                                error_o
);

  frac_pkg::raw_t fq_wdata, fq_rdata;
  logic fq_push, fq_full, fq_pop, fq_empty;

  frac_front u_front (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .push_i          (push),
    .full_o          (full),
    .operation_i     (operation_i),
    .p_numerator_i   (p_numerator_i),
    .p_denominator_i (p_denominator_i),
    .q_numerator_i   (q_numerator_i),
    .q_denominator_i (q_denominator_i),
    .q_full_i        (fq_full),
    .q_push_o        (fq_push),
    .q_data_o        (fq_wdata)
  );

  // decouples the multiply front from the iterative back end
  frac_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (fq_push),
    .full_o  (fq_full),
    .wdata_i (fq_wdata),
    .pop_i   (fq_pop),
    .empty_o (fq_empty),
    .rdata_o (fq_rdata)
  );

  frac_back u_back (
    .clk_i                (clk_i),
    .rst_ni               (rst_ni),
    .q_empty_i            (fq_empty),
    .q_pop_o              (fq_pop),
    .q_data_i             (fq_rdata),
    .empty_o              (empty),
    .pop_i                (pop),
    .result_numerator_o   (result_numerator_o),
    .result_denominator_o (result_denominator_o),
    .error_o              (error_o)
  );

endmodule

// ----- rtl/frac_chk.sv -----
// Port-level checks for the fraction reducer, bound to the top level.
`include "fraction_arith_reduce_assert.svh"

module frac_chk (
  input logic                              clk_i,
  input logic                              rst_ni,
  input logic                              empty,
  input logic                              pop,
  input logic signed [frac_pkg::NUM_W-1:0] result_numerator_o,
  input logic signed [frac_pkg::DEN_W-1:0] result_denominator_o,
  input logic                              error_o
);

  // error beats carry 0/0
  `FAR_ASSERT_IMP(a_err_zero, clk_i, rst_ni, !empty && error_o, (result_numerator_o == '0) && (result_denominator_o == '0))
  // zero denominator without error means +1/0 or -1/0
  `FAR_ASSERT_IMP(a_inf_unit, clk_i, rst_ni, !empty && !error_o && (result_denominator_o == '0), (result_numerator_o == 33'sd1) || (result_numerator_o == -33'sd1))
  // nonzero numerator means the sign was moved off the denominator
  `FAR_ASSERT_IMP(a_den_pos, clk_i, rst_ni, !empty && !error_o && (result_numerator_o != '0), !result_denominator_o[frac_pkg::DEN_W-1])
  // a waiting result stays until taken
  `FAR_ASSERT_NXT(a_hold, clk_i, rst_ni, !empty && !pop, !empty && $stable(result_numerator_o))

endmodule

bind fraction_arith_reduce frac_chk u_frac_chk (
  .clk_i                (clk_i),
  .rst_ni               (rst_ni),
  .empty                (empty),
  .pop                  (pop),
  .result_numerator_o   (result_numerator_o),
  .result_denominator_o (result_denominator_o),
  .error_o              (error_o)
);

// ----- tb/sv/fraction_arith_reduce_tb.sv -----
// Testbench for fraction_arith_reduce: queue-style push/pop, predicted results checked per beat.
module fraction_arith_reduce_tb;

  typedef struct {
    logic signed [frac_pkg::NUM_W-1:0] num;
    logic signed [frac_pkg::DEN_W-1:0] den;
    logic                              err;
  } frac_res_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic push = 1'b0;
  logic pop = 1'b0;
  logic [1:0] operation_i = '0;
  logic signed [frac_pkg::OW-1:0] p_numerator_i = '0, p_denominator_i = '0;
  logic signed [frac_pkg::OW-1:0] q_numerator_i = '0, q_denominator_i = '0;
  logic full, empty, error_o;
  logic signed [frac_pkg::NUM_W-1:0] result_numerator_o;
  logic signed [frac_pkg::DEN_W-1:0] result_denominator_o;

  frac_res_t reduced_q[$];
  int        mismatches = 0;
  int        send_idle_pct = 0;  // sender idle chance, percent
  int        recv_stall_pct = 0; // receiver stall chance, percent
  int        hold_cycles = 0;    // long receiver hold-off, set by a test

  fraction_arith_reduce u_top (.*);

  always #1 clk_i = ~clk_i;

  // Predict the reduced fraction. Raw terms fit in 34 signed bits at width 16,
  // so plain signed 64-bit math is exact.
  function automatic frac_res_t reduce_frac(frac_pkg::op_e op,
                                            logic signed [frac_pkg::OW-1:0] pn,
                                            logic signed [frac_pkg::OW-1:0] pd,
                                            logic signed [frac_pkg::OW-1:0] qn,
                                            logic signed [frac_pkg::OW-1:0] qd);
    longint n, d, a, b, t;
    frac_res_t r;
    case (op)
      frac_pkg::OP_ADD: begin
        n = longint'(pn) * qd + longint'(pd) * qn; d = longint'(pd) * qd;
      end
      frac_pkg::OP_SUB: begin
        n = longint'(pn) * qd - longint'(pd) * qn; d = longint'(pd) * qd;
      end
      frac_pkg::OP_MUL: begin n = longint'(pn) * qn; d = longint'(pd) * qd; end
      default: begin n = longint'(pn) * qd; d = longint'(pd) * qn; end
    endcase
    r.err = 1'b0;
    if (n == 0 && d == 0) begin
      r.num = '0; r.den = '0; r.err = 1'b1;
      return r;
    end
    a = (n < 0) ? -n : n;
    b = (d < 0) ? -d : d;
    while (b != 0) begin
      t = a % b; a = b; b = t;
    end
    n = n / a;
    d = d / a;
    // sign moves to the numerator unless the result is zero
    if (d < 0 && n != 0) begin
      n = -n; d = -d;
    end
    r.num = n[frac_pkg::NUM_W-1:0];
    r.den = d[frac_pkg::DEN_W-1:0];
    return r;
  endfunction

  // push stays high between back-to-back beats; it drops while idling
  task automatic send_beat(frac_pkg::op_e op, logic signed [frac_pkg::OW-1:0] pn,
                           logic signed [frac_pkg::OW-1:0] pd,
                           logic signed [frac_pkg::OW-1:0] qn,
                           logic signed [frac_pkg::OW-1:0] qd);
    while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
      push <= 1'b0;
      @(negedge clk_i);
    end
    push <= 1'b1;
    operation_i <= op;
    p_numerator_i <= pn; p_denominator_i <= pd;
    q_numerator_i <= qn; q_denominator_i <= qd;
    do @(posedge clk_i); while (full);
    reduced_q.push_back(reduce_frac(op, pn, pd, qn, qd));
    @(negedge clk_i);
  endtask

  task automatic wait_drained();
    push <= 1'b0;
    while (reduced_q.size() != 0) @(negedge clk_i);
  endtask

  function automatic logic signed [frac_pkg::OW-1:0] rand_operand();
    case ($urandom_range(5))
      0: return logic'($urandom_range(3)) ? frac_pkg::OW'($urandom_range(3)) : '0;
      1: return -$signed(frac_pkg::OW'($urandom_range(4)));
      2: return {1'b1, {(frac_pkg::OW-1){1'b0}}};
      3: return {1'b0, {(frac_pkg::OW-1){1'b1}}};
      4: return frac_pkg::OW'(int'($urandom_range(40)) * (($urandom_range(1)) ? 1 : -1));
      default: return frac_pkg::OW'($urandom);
    endcase
  endfunction

  // receiver: pop at the falling edge, sample at the rising edge
  always @(negedge clk_i) begin
    if (hold_cycles > 0) begin
      hold_cycles <= hold_cycles - 1;
      pop <= 1'b0;
    end else begin
      pop <= !(recv_stall_pct > 0 && $urandom_range(99) < recv_stall_pct);
    end
  end

  always @(posedge clk_i) begin
    frac_res_t e;
    if (rst_ni && pop && !empty) begin
      if (reduced_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result beat %0d/%0d",
                                       result_numerator_o, result_denominator_o);
      end else begin
        e = reduced_q.pop_front();
        if (result_numerator_o !== e.num || result_denominator_o !== e.den
            || error_o !== e.err) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: exp %0d/%0d err %0b, got %0d/%0d err %0b", e.num, e.den,
                     e.err, result_numerator_o, result_denominator_o, error_o);
        end
      end
    end
  end

  task automatic test_directed();
    logic signed [frac_pkg::OW-1:0] mx, mn;
    mx = {1'b0, {(frac_pkg::OW-1){1'b1}}};
    mn = {1'b1, {(frac_pkg::OW-1){1'b0}}};
    send_beat(frac_pkg::OP_ADD, 1, 2, 1, 3);
    send_beat(frac_pkg::OP_SUB, 1, 2, 1, 2);     // zero result, positive den
    send_beat(frac_pkg::OP_SUB, 1, -2, 1, -2);   // zero result, both denominators negative
    send_beat(frac_pkg::OP_MUL, 3, -4, 2, 9);    // sign moved to numerator
    send_beat(frac_pkg::OP_DIV, 5, 7, 0, 3);     // divide by zero fraction
    send_beat(frac_pkg::OP_DIV, -5, 7, 0, 3);
    send_beat(frac_pkg::OP_MUL, 0, 0, 4, 5);     // both raw terms zero
    send_beat(frac_pkg::OP_ADD, mn, 1, mn, 1);   // full-scale negative sum
    send_beat(frac_pkg::OP_ADD, mn, -1, mn, -1); // full-scale positive sum, +2^16
    send_beat(frac_pkg::OP_SUB, mx, 1, mn, 1);
    send_beat(frac_pkg::OP_MUL, mn, mn, mn, mn);
    send_beat(frac_pkg::OP_MUL, mn, mx, mx, mn);
    send_beat(frac_pkg::OP_DIV, mx, mn, mn, mx);
    send_beat(frac_pkg::OP_ADD, 0, 0, 0, 0);
    send_beat(frac_pkg::OP_DIV, 0, 5, 0, 7);
    send_beat(frac_pkg::OP_ADD, -1, -1, -1, -1);
    send_beat(frac_pkg::OP_SUB, mx, mx, mx, mn);
    send_beat(frac_pkg::OP_MUL, 12345, -6789, -13, 26);
    wait_drained();
  endtask

  task automatic test_random(int count, int idle, int stall);
    send_idle_pct = idle;
    recv_stall_pct = stall;
    repeat (count)
      send_beat(frac_pkg::op_e'($urandom_range(3)), rand_operand(), rand_operand(),
                rand_operand(), rand_operand());
    wait_drained();
  endtask

  // receiver holds off while sender keeps pushing, so input backs up
  task automatic test_backpressure();
    send_idle_pct = 0;
    recv_stall_pct = 0;
    hold_cycles = 600;
    repeat (12)
      send_beat(frac_pkg::op_e'($urandom_range(3)), rand_operand(), rand_operand(),
                rand_operand(), rand_operand());
    wait_drained();
  endtask

  initial begin
    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);
    test_directed();
    test_random(350, 0, 0);
    test_random(350, 83, 0);
    test_random(350, 0, 83);
    test_random(350, 20, 20);
    test_backpressure();
    test_random(100, 0, 0);
    repeat (300) @(negedge clk_i);
    if (mismatches == 0 && reduced_q.size() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  initial begin
    #4000000;
    $display("DONE: errors detected");
    $finish;
  end
endmodule
